>>> design/rud_pkg.sv
// shared constants and types for the restoring unsigned divider
`default_nettype none

package rud_pkg;

    localparam int DATA_W        = 16;
    localparam int CFG_W         = 5;
    localparam int WIDTH_DEFAULT = 16;

    localparam logic [CFG_W-1:0] OPERAND_BITS_RESET = 5'd16;

    // per-cycle controls broadcast along the cell row
    typedef struct packed {
        logic load;
        logic step;
        logic keep;
    } rud_cell_ctrl_t;

endpackage

`default_nettype wire

>>> design/rud_cfg_if.sv
// configuration write channel carrying the operand bit count
`default_nettype none

interface rud_cfg_if;
    import rud_pkg::*;

    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] operand_bits;

    modport source (output valid, output operand_bits, input ready);
    modport sink (input valid, input operand_bits, output ready);

endinterface

`default_nettype wire

>>> design/rud_in_if.sv
// operand channel carrying dividend and divisor
`default_nettype none

interface rud_in_if;
    import rud_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;

    modport source (output valid, output dividend, output divisor, input ready);
    modport sink (input valid, input dividend, input divisor, output ready);

endinterface

`default_nettype wire

>>> design/rud_out_if.sv
// result channel carrying quotient and remainder
`default_nettype none

interface rud_out_if;
    import rud_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] quotient;
    logic [DATA_W-1:0] remainder;

    modport source (output valid, output quotient, output remainder, input ready);
    modport sink (input valid, input quotient, input remainder, output ready);

endinterface

`default_nettype wire

>>> design/rud_cell.sv
// one bit slice of the divider: remainder, quotient and divisor bits with a borrow stage
`default_nettype none

module rud_cell (
    input  wire logic                    clk,
    input  wire rud_pkg::rud_cell_ctrl_t ctrl,
    input  wire logic                    load_q,
    input  wire logic                    load_m,
    input  wire logic                    a_in,
    input  wire logic                    q_in,
    input  wire logic                    borrow_in,
    output logic                         a,
    output logic                         q,
    output logic                         m,
    output logic                         borrow_out
);
    import rud_pkg::*;

    logic a_reg, a_next;
    logic q_reg, q_next;
    logic m_reg, m_next;
    logic diff;

    // trial subtract of the divisor bit from the shifted remainder bit
    assign diff       = a_in ^ m_reg ^ borrow_in;
    assign borrow_out = (~a_in & m_reg) | (~a_in & borrow_in) | (m_reg & borrow_in);

    always_comb
    begin
        a_next = a_reg;
        q_next = q_reg;
        m_next = m_reg;
        if (ctrl.load)
        begin
            a_next = 1'b0;
            q_next = load_q;
            m_next = load_m;
        end
        else if (ctrl.step)
        begin
            a_next = ctrl.keep ? diff : a_in;
            q_next = q_in;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        q_reg <= q_next;
        m_reg <= m_next;
    end

    assign a = a_reg;
    assign q = q_reg;
    assign m = m_reg;

endmodule

`default_nettype wire

>>> design/restoring_unsigned_divider.sv
// restoring unsigned divider: one quotient bit per cycle through a row of bit-slice cells
// n = operand_bits clamped to 1..WIDTH gives the quotient bits computed; the result then goes to the output register
// a new item is accepted only as the previous one finishes; each round runs one borrow ripple across the row
// a waiting result sits in the output register while the next item is accepted
// reset (rst_n low, asynchronous) clears control and valid flags and sets operand_bits to 16
`default_nettype none

module restoring_unsigned_divider #(
    parameter int WIDTH = rud_pkg::WIDTH_DEFAULT
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rud_cfg_if.sink    cfg,
    rud_in_if.sink     operands,
    rud_out_if.source  results
);
    import rud_pkg::*;

    localparam int CW    = WIDTH + 1;
    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [CFG_W-1:0]  operand_bits_reg, operand_bits_next;
    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] quotient_reg, quotient_next;
    logic [DATA_W-1:0] remainder_reg, remainder_next;

    logic [CNT_W-1:0]  n_eff;
    logic [CNT_W-1:0]  align_sh;
    logic [CW-1:0]     mask;
    logic [CW-1:0]     q_load;
    logic [CW-1:0]     m_load;
    logic [CW-1:0]     a_vec, q_vec, m_vec, borrow_vec;
    logic [CW-1:0]     a_shift_in, q_shift_in, borrow_in_vec;
    logic              accept;
    logic              finish;
    logic              in_ready;
    rud_cell_ctrl_t    ctrl;

    // clamp the configured bit count to 1..WIDTH
    always_comb
    begin
        if (operand_bits_reg == '0)
            n_eff = CNT_W'(1);
        else if (32'(operand_bits_reg) > WIDTH)
            n_eff = CNT_W'(WIDTH);
        else
            n_eff = CNT_W'(operand_bits_reg);
    end

    // dividend is left-aligned so its top active bit sits in the top cell
    assign align_sh = CNT_W'(WIDTH + 1 - 32'(n_eff));
    assign mask     = ~({CW{1'b1}} << n_eff);
    assign q_load   = CW'(operands.dividend) << align_sh;
    assign m_load   = CW'(operands.divisor) & mask;

    assign finish   = busy_reg && (count_reg == '0) && (!out_valid_reg || results.ready);
    assign in_ready = !busy_reg || finish;
    assign accept   = operands.valid && in_ready;

    assign ctrl.load = accept;
    assign ctrl.step = busy_reg && (count_reg != '0);
    assign ctrl.keep = ~borrow_vec[CW-1];

    assign a_shift_in    = {a_vec[CW-2:0], q_vec[CW-1]};
    assign q_shift_in    = {q_vec[CW-2:0], ctrl.keep};
    assign borrow_in_vec = {borrow_vec[CW-2:0], 1'b0};

    for (genvar i = 0; i < CW; i++)
    begin : g_cell
        rud_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .load_q     (q_load[i]),
            .load_m     (m_load[i]),
            .a_in       (a_shift_in[i]),
            .q_in       (q_shift_in[i]),
            .borrow_in  (borrow_in_vec[i]),
            .a          (a_vec[i]),
            .q          (q_vec[i]),
            .m          (m_vec[i]),
            .borrow_out (borrow_vec[i])
        );
    end

    always_comb
    begin
        operand_bits_next = operand_bits_reg;
        busy_next         = busy_reg;
        count_next        = count_reg;
        out_valid_next    = out_valid_reg;
        quotient_next     = quotient_reg;
        remainder_next    = remainder_reg;

        if (cfg.valid)
            operand_bits_next = cfg.operand_bits;

        if (results.ready)
            out_valid_next = 1'b0;

        if (finish)
        begin
            busy_next      = 1'b0;
            out_valid_next = 1'b1;
            quotient_next  = DATA_W'(q_vec[WIDTH-1:0]);
            remainder_next = DATA_W'(a_vec[WIDTH-1:0]);
        end

        if (accept)
        begin
            busy_next  = 1'b1;
            count_next = n_eff;
        end
        else if (ctrl.step)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            operand_bits_reg <= OPERAND_BITS_RESET;
            busy_reg         <= 1'b0;
            count_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            operand_bits_reg <= operand_bits_next;
            busy_reg         <= busy_next;
            count_reg        <= count_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quotient_reg  <= quotient_next;
        remainder_reg <= remainder_next;
    end

    assign cfg.ready         = 1'b1;
    assign operands.ready    = in_ready;
    assign results.valid     = out_valid_reg;
    assign results.quotient  = quotient_reg;
    assign results.remainder = remainder_reg;

    // a new transaction starts a full run of rounds
    a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg && (count_reg == $past(n_eff)))
        else $error("round counter not loaded on operand transaction");

    // no item leaves before its rounds are done
    a_no_early_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && (count_reg != '0)) |=> busy_reg)
        else $error("divider left busy before rounds completed");

    // a result only appears from a completed run
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(results.valid) |-> $past(busy_reg && (count_reg == '0)))
        else $error("result valid without a completed run");

    // final partial remainder is below a nonzero divisor
    a_remainder_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && (count_reg == '0) && (m_vec != '0)) |-> (a_vec < m_vec))
        else $error("remainder not below divisor");

endmodule

`default_nettype wire
